[hw/rtl/mfmsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmsf_pkg
// shared types, codes and the crc-ccitt byte update for the sector finder
// ----------------------------------------------------------------------------
package mfmsf_pkg;

  localparam int POS_W   = 13;
  localparam int COUNT_W = 11;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_PRESET   = 16'hcdb4;
  localparam logic [47:0] SYNC_PATTERN = 48'h0000_00a1_a1a1;
  localparam logic [7:0]  MARK_ID      = 8'hfe;
  localparam logic [7:0]  MARK_DATA    = 8'hfb;
  localparam logic [COUNT_W-1:0] BASE_SIZE = 11'd128;
  localparam logic [POS_W-1:0]   POS_MAX   = 13'd8191;

  // config register indexes
  localparam logic [1:0] CFG_TRACK  = 2'd0;
  localparam logic [1:0] CFG_SIDE   = 2'd1;
  localparam logic [1:0] CFG_SECTOR = 2'd2;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_ID     = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_WRONG_ID  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] track;
    logic       side;
    logic [7:0] sector;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       id_crc_bad;
    logic       data_crc_bad;
    logic       last;
  } res_t;

  typedef struct packed {
    logic emit;
    logic search_done;
  } stat_t;

  // msb-first crc-ccitt over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/mfmsf_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfmsf_parser
// track parse state and the per-byte sync, id and data field logic
// ----------------------------------------------------------------------------
module mfmsf_parser #(
  parameter int TRACK_LEN = 6250
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          track_byte,
  input  logic                track_start,
  input  mfmsf_pkg::cfg_t     cfg,
  output mfmsf_pkg::stat_t    stat,
  output mfmsf_pkg::res_t     res
);

  localparam logic [mfmsf_pkg::POS_W-1:0] LAST_POS = mfmsf_pkg::POS_W'(TRACK_LEN - 1);
  localparam logic [mfmsf_pkg::POS_W-1:0] LEN_POS  = mfmsf_pkg::POS_W'(TRACK_LEN);

  logic [47:0]                      sync_window, sync_window_next;
  logic [2:0]                       window_fill, window_fill_next;
  mfmsf_pkg::phase_t                parse_phase, parse_phase_next;
  logic [mfmsf_pkg::COUNT_W-1:0]    field_count, field_count_next;
  logic [mfmsf_pkg::POS_W-1:0]      track_position, track_position_next;
  logic [15:0]                      running_crc, running_crc_next;
  logic [15:0]                      received_crc, received_crc_next;
  logic                             sector_match, sector_match_next;
  logic [1:0]                       size_code, size_code_next;
  logic                             id_bad_flag, id_bad_flag_next;
  logic                             search_done, search_done_next;

  // state as seen by this byte (track start clears it first)
  logic [47:0]                      cur_window;
  logic [2:0]                       cur_fill;
  mfmsf_pkg::phase_t                cur_phase;
  logic [mfmsf_pkg::COUNT_W-1:0]    cur_count;
  logic [mfmsf_pkg::POS_W-1:0]      cur_pos;
  logic [15:0]                      cur_crc;
  logic [15:0]                      cur_rcv;
  logic                             cur_match;
  logic [1:0]                       cur_size;
  logic                             cur_idbad;
  logic                             cur_done;

  logic                             synced;
  logic [mfmsf_pkg::COUNT_W-1:0]    field_size;
  logic [mfmsf_pkg::POS_W:0]        id_end;
  logic [mfmsf_pkg::POS_W:0]        data_end;
  logic [15:0]                      rcv_full;
  logic                             emit;
  mfmsf_pkg::res_t                  res_c;

  always_comb begin
    cur_window = track_start ? 48'd0 : sync_window;
    cur_fill   = track_start ? 3'd0 : window_fill;
    cur_phase  = track_start ? mfmsf_pkg::PH_SEARCH : parse_phase;
    cur_count  = track_start ? '0 : field_count;
    cur_pos    = track_start ? '0 : track_position;
    cur_crc    = track_start ? mfmsf_pkg::CRC_PRESET : running_crc;
    cur_rcv    = track_start ? 16'd0 : received_crc;
    cur_match  = track_start ? 1'b0 : sector_match;
    cur_size   = track_start ? 2'd0 : size_code;
    cur_idbad  = track_start ? 1'b0 : id_bad_flag;
    cur_done   = track_start ? 1'b0 : search_done;
  end

  assign synced     = (cur_fill == 3'd6) && (cur_window == mfmsf_pkg::SYNC_PATTERN);
  assign field_size = mfmsf_pkg::BASE_SIZE << cur_size;
  assign id_end     = {1'b0, cur_pos} + (mfmsf_pkg::POS_W + 1)'(6);
  assign data_end   = {1'b0, cur_pos} + (mfmsf_pkg::POS_W + 1)'(field_size)
                    + (mfmsf_pkg::POS_W + 1)'(2);
  assign rcv_full   = {cur_rcv[15:8], track_byte};

  always_comb begin
    sync_window_next  = cur_window;
    window_fill_next  = cur_fill;
    parse_phase_next  = cur_phase;
    field_count_next  = cur_count;
    running_crc_next  = cur_crc;
    received_crc_next = cur_rcv;
    sector_match_next = cur_match;
    size_code_next    = cur_size;
    id_bad_flag_next  = cur_idbad;
    search_done_next  = cur_done;
    emit              = 1'b0;
    res_c             = '0;

    if (!cur_done && (cur_pos < LEN_POS)) begin
      unique case (cur_phase)
        mfmsf_pkg::PH_SEARCH: begin
          if (synced && (track_byte == mfmsf_pkg::MARK_ID)) begin
            if (id_end > {1'b0, LAST_POS}) begin
              emit             = 1'b1;
              res_c.kind       = mfmsf_pkg::KIND_NOT_FOUND;
              search_done_next = 1'b1;
            end else begin
              parse_phase_next = mfmsf_pkg::PH_ID;
              field_count_next = '0;
              running_crc_next = mfmsf_pkg::crc_byte(mfmsf_pkg::CRC_PRESET, track_byte);
              sync_window_next = 48'd0;
              window_fill_next = 3'd0;
            end
          end else if (synced && (track_byte == mfmsf_pkg::MARK_DATA)) begin
            if (data_end > {1'b0, LAST_POS}) begin
              emit             = 1'b1;
              res_c.kind       = mfmsf_pkg::KIND_NOT_FOUND;
              search_done_next = 1'b1;
            end else begin
              parse_phase_next = cur_match ? mfmsf_pkg::PH_DATA : mfmsf_pkg::PH_SKIP;
              field_count_next = '0;
              running_crc_next = mfmsf_pkg::crc_byte(mfmsf_pkg::CRC_PRESET, track_byte);
              sync_window_next = 48'd0;
              window_fill_next = 3'd0;
            end
          end else begin
            sync_window_next = {cur_window[39:0], track_byte};
            if (cur_fill < 3'd6) begin
              window_fill_next = cur_fill + 3'd1;
            end
          end
        end
        mfmsf_pkg::PH_ID: begin
          if (cur_count < mfmsf_pkg::COUNT_W'(4)) begin
            running_crc_next = mfmsf_pkg::crc_byte(cur_crc, track_byte);
          end
          field_count_next = cur_count + mfmsf_pkg::COUNT_W'(1);
          priority if ((cur_count == mfmsf_pkg::COUNT_W'(0)) && (track_byte != cfg.track)) begin
            emit             = 1'b1;
            res_c.kind       = mfmsf_pkg::KIND_WRONG_ID;
            search_done_next = 1'b1;
          end else if ((cur_count == mfmsf_pkg::COUNT_W'(1))
                       && (track_byte != {7'd0, cfg.side})) begin
            emit             = 1'b1;
            res_c.kind       = mfmsf_pkg::KIND_WRONG_ID;
            search_done_next = 1'b1;
          end else if (cur_count == mfmsf_pkg::COUNT_W'(2)) begin
            sector_match_next = (track_byte == cfg.sector);
          end else if (cur_count == mfmsf_pkg::COUNT_W'(3)) begin
            size_code_next = track_byte[1:0];
          end else if (cur_count == mfmsf_pkg::COUNT_W'(4)) begin
            received_crc_next = {track_byte, 8'd0};
          end else if (cur_count == mfmsf_pkg::COUNT_W'(5)) begin
            received_crc_next = rcv_full;
            id_bad_flag_next  = (rcv_full != cur_crc);
            parse_phase_next  = mfmsf_pkg::PH_SEARCH;
            field_count_next  = '0;
            sync_window_next  = 48'd0;
            window_fill_next  = 3'd0;
          end else begin
          end
        end
        mfmsf_pkg::PH_SKIP, mfmsf_pkg::PH_DATA: begin
          if (cur_count < field_size) begin
            running_crc_next = mfmsf_pkg::crc_byte(cur_crc, track_byte);
            field_count_next = cur_count + mfmsf_pkg::COUNT_W'(1);
            if (cur_phase == mfmsf_pkg::PH_DATA) begin
              emit            = 1'b1;
              res_c.kind      = mfmsf_pkg::KIND_DATA;
              res_c.data_byte = track_byte;
            end
          end else if (cur_count == field_size) begin
            received_crc_next = {track_byte, 8'd0};
            field_count_next  = cur_count + mfmsf_pkg::COUNT_W'(1);
          end else begin
            received_crc_next = rcv_full;
            if (cur_phase == mfmsf_pkg::PH_DATA) begin
              emit               = 1'b1;
              res_c.kind         = mfmsf_pkg::KIND_DONE;
              res_c.id_crc_bad   = cur_idbad;
              res_c.data_crc_bad = (rcv_full != cur_crc);
              search_done_next   = 1'b1;
            end else begin
              parse_phase_next = mfmsf_pkg::PH_SEARCH;
              field_count_next = '0;
              sync_window_next = 48'd0;
              window_fill_next = 3'd0;
            end
          end
        end
        default: begin
        end
      endcase

      // end of track with the search still open
      if (!emit && (cur_pos == LAST_POS)) begin
        emit             = 1'b1;
        res_c            = '0;
        res_c.kind       = mfmsf_pkg::KIND_NOT_FOUND;
        search_done_next = 1'b1;
      end
    end

    res_c.last = emit && (res_c.kind != mfmsf_pkg::KIND_DATA);

    track_position_next = (cur_pos < mfmsf_pkg::POS_MAX) ? cur_pos + mfmsf_pkg::POS_W'(1)
                                                         : cur_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_window    <= 48'd0;
      window_fill    <= 3'd0;
      parse_phase    <= mfmsf_pkg::PH_SEARCH;
      field_count    <= '0;
      track_position <= '0;
      running_crc    <= mfmsf_pkg::CRC_PRESET;
      received_crc   <= 16'd0;
      sector_match   <= 1'b0;
      size_code      <= 2'd0;
      id_bad_flag    <= 1'b0;
      search_done    <= 1'b0;
    end else if (step) begin
      sync_window    <= sync_window_next;
      window_fill    <= window_fill_next;
      parse_phase    <= parse_phase_next;
      field_count    <= field_count_next;
      track_position <= track_position_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
      sector_match   <= sector_match_next;
      size_code      <= size_code_next;
      id_bad_flag    <= id_bad_flag_next;
      search_done    <= search_done_next;
    end
  end

  assign stat.emit        = emit;
  assign stat.search_done = search_done;
  assign res              = res_c;

endmodule

[hw/rtl/mfm_track_sector_finder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_track_sector_finder_unit
// finds one sector in a raw mfm track and streams its data, if found, plus a status
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   --------  ----  ---------------------  --------------------------------------
//   in        in    in_valid / in_ready    track_byte, track_start
//   out       out   out_valid / out_ready  kind, data_byte, id_crc_bad,
//                                          data_crc_bad, last
//   cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one track byte per cycle: each request is parsed in the cycle it is taken,
// the crc byte update and field compares sit between the parse state and the
// result register, so a result shows in the cycle after its request is taken
// in_ready drops only while a result waits in the output register and out_ready
// is low; a waiting result is freed and replaced in the same cycle
// rst clears the parse state as at track start and restores target track 0,
// side 0, sector 1; no clearing pass is needed
// cfg writes are always taken (cfg_ready is tied high), unknown indexes ignored
//
module mfm_track_sector_finder_unit #(
  parameter int TRACK_LEN = 6250
) (
  input  logic       clk,
  input  logic       rst,
  // track byte requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] track_byte,
  input  logic       track_start,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic       id_crc_bad,
  output logic       data_crc_bad,
  output logic       last,
  // register writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  mfmsf_pkg::cfg_t  cfg;
  mfmsf_pkg::stat_t stat;
  mfmsf_pkg::res_t  res;
  mfmsf_pkg::res_t  out_res;
  logic             in_acc;

  // output register can take a new result when empty or being drained
  assign in_ready  = !out_valid || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // target registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track  <= 8'd0;
      cfg.side   <= 1'b0;
      cfg.sector <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mfmsf_pkg::CFG_TRACK:  cfg.track  <= cfg_data;
        mfmsf_pkg::CFG_SIDE:   cfg.side   <= cfg_data[0];
        mfmsf_pkg::CFG_SECTOR: cfg.sector <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mfmsf_parser #(
    .TRACK_LEN (TRACK_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (in_acc),
    .track_byte  (track_byte),
    .track_start (track_start),
    .cfg         (cfg),
    .stat        (stat),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && stat.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && stat.emit) begin
      out_res <= res;
    end
  end

  assign kind         = out_res.kind;
  assign data_byte    = out_res.data_byte;
  assign id_crc_bad   = out_res.id_crc_bad;
  assign data_crc_bad = out_res.data_crc_bad;
  assign last         = out_res.last;

  // status item always closes the search
  a_last_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind != mfmsf_pkg::KIND_DATA)))
    else $error("last flag disagrees with result kind");

  // no request taken while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted over a stalled result");

  // a status result marks the search done
  a_status_ends_search: assert property (@(posedge clk) disable iff (rst)
    (in_acc && stat.emit && res.last) |=> stat.search_done)
    else $error("search not closed after status result");

  // nothing more until the next track start
  a_quiet_after_done: assert property (@(posedge clk) disable iff (rst)
    (in_acc && stat.search_done && !track_start) |-> !stat.emit)
    else $error("result produced after the search closed");

endmodule
